[hw/rtl/ec_pkg.sv]
// ec_pkg: shared types, constants and month-length table for the epoch to
// calendar converter. No dependencies.
`default_nettype none

package ec_pkg;

	// Calendar constants
	localparam int unsigned SECS_PER_DAY  = 86400;
	localparam int unsigned SECS_PER_HOUR = 3600;
	localparam int unsigned SECS_PER_MIN  = 60;
	localparam int unsigned DAYS_PER_WEEK = 7;
	localparam int unsigned EPOCH_YEAR    = 1970;
	localparam int unsigned EPOCH_WDAY    = 4;	// 1970-01-01 was a Thursday
	localparam int unsigned DAYS_LEAP     = 366;
	localparam int unsigned DAYS_NORM     = 365;
	localparam int unsigned LAST_MONTH    = 11;

	// Year residues at the epoch, for the leap rule
	localparam int unsigned EPOCH_MOD4    = EPOCH_YEAR % 4;
	localparam int unsigned EPOCH_MOD100  = EPOCH_YEAR % 100;
	localparam int unsigned EPOCH_MOD400  = EPOCH_YEAR % 400;

	// Month index codes used by the table
	localparam logic [3:0] MON_JAN = 4'd0;
	localparam logic [3:0] MON_FEB = 4'd1;
	localparam logic [3:0] MON_MAR = 4'd2;
	localparam logic [3:0] MON_APR = 4'd3;
	localparam logic [3:0] MON_MAY = 4'd4;
	localparam logic [3:0] MON_JUN = 4'd5;
	localparam logic [3:0] MON_JUL = 4'd6;
	localparam logic [3:0] MON_AUG = 4'd7;
	localparam logic [3:0] MON_SEP = 4'd8;
	localparam logic [3:0] MON_OCT = 4'd9;
	localparam logic [3:0] MON_NOV = 4'd10;
	localparam logic [3:0] MON_DEC = 4'd11;

	// Broken-down result
	typedef struct packed {
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [8:0]  day_of_year;
		logic [2:0]  weekday;
	} ec_res_t;

	// Sequencer status towards the handshake logic
	typedef struct packed {
		logic idle;
		logic done;
	} ec_stat_t;

	// Days in a month
	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
		logic [4:0] len;
		unique case (mon)
			MON_FEB: len = leap ? 5'd29 : 5'd28;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
			MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/epoch_seconds_to_calendar.sv]
// epoch_seconds_to_calendar: top level, handshake and output register.
// Depends on ec_pkg and ec_seq (which holds ec_sub_unit).
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+---------------------------------------------
//  input    | in_valid, in_ready  | epoch_seconds
//  output   | out_valid, out_ready| second, minute, hour, year, month,
//           |                     | day_of_month, day_of_year, weekday
//
// The single subtractor sets how long a transaction takes to reach the output
// register: 40 divide steps, one step per year since 1970 and one per month.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register, and a new transaction may be taken meanwhile.
// Reset (arst_n low) clears out_valid and returns the sequencer to idle.
`default_nettype none

module epoch_seconds_to_calendar
	import ec_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] epoch_seconds,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       second,
	output logic [5:0]       minute,
	output logic [4:0]       hour,
	output logic [11:0]      year,
	output logic [3:0]       month,
	output logic [4:0]       day_of_month,
	output logic [8:0]       day_of_year,
	output logic [2:0]       weekday
);

	ec_stat_t stat;
	ec_res_t  res;
	ec_res_t  res_q;
	logic     out_valid_q;
	logic     take;

	// Result moves out when the output register is free or being emptied
	assign take     = stat.done && (!out_valid_q || out_ready);
	assign in_ready = stat.idle;

	ec_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (in_valid && in_ready),
		.epoch_seconds (epoch_seconds),
		.take          (take),
		.stat          (stat),
		.res           (res)
	);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign second       = res_q.second;
	assign minute       = res_q.minute;
	assign hour         = res_q.hour;
	assign year         = res_q.year;
	assign month        = res_q.month;
	assign day_of_month = res_q.day_of_month;
	assign day_of_year  = res_q.day_of_year;
	assign weekday      = res_q.weekday;

endmodule

`default_nettype wire

[hw/rtl/ec_sub_unit.sv]
// ec_sub_unit: the shared 32-bit compare-and-subtract unit.
// Depends on nothing; used by ec_seq for every division and reduction step.
`default_nettype none

module ec_sub_unit (
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic             ge,
	output logic [31:0]      diff
);

	logic borrow;

	// One wide subtract; no borrow means a >= b
	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
	assign ge = ~borrow;

endmodule

`default_nettype wire

[hw/rtl/ec_seq.sv]
// ec_seq: sequencer and datapath that drive ec_sub_unit through day, hour,
// minute, weekday, year and month reduction. Depends on ec_pkg, ec_sub_unit.
`default_nettype none

module ec_seq
	import ec_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] epoch_seconds,
	input  wire logic        take,
	output ec_stat_t         stat,
	output ec_res_t          res
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DAY  = 3'd1;
	localparam logic [2:0] ST_HOUR = 3'd2;
	localparam logic [2:0] ST_MIN  = 3'd3;
	localparam logic [2:0] ST_WDAY = 3'd4;
	localparam logic [2:0] ST_YEAR = 3'd5;
	localparam logic [2:0] ST_MON  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	// Top quotient bit index of each restoring division
	localparam logic [3:0] TOP_DAY  = 4'd15;	// days < 2^16
	localparam logic [3:0] TOP_HOUR = 4'd4;	// hours < 2^5
	localparam logic [3:0] TOP_MIN  = 4'd5;	// minutes < 2^6
	localparam logic [3:0] TOP_WDAY = 4'd12;	// weeks < 2^13

	logic [2:0]  state_q;
	logic [31:0] rem_q;
	logic [15:0] quo_q;
	logic [3:0]  cnt_q;
	logic [15:0] days_q;
	logic [11:0] year_q;
	logic [1:0]  m4_q;
	logic [6:0]  m100_q;
	logic [8:0]  m400_q;
	logic [3:0]  mon_q;
	logic [5:0]  second_q;
	logic [5:0]  minute_q;
	logic [4:0]  hour_q;
	logic [8:0]  yday_q;
	logic [2:0]  wday_q;

	logic [31:0] sub_b;
	logic        ge;
	logic [31:0] diff;
	logic [31:0] rem_nxt;
	logic [15:0] quo_nxt;
	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  mlen;

	// Leap rule from running residues of the year
	assign leap = (m400_q == 9'd0) || ((m4_q == 2'd0) && (m100_q != 7'd0));
	assign ylen = leap ? 9'(DAYS_LEAP) : 9'(DAYS_NORM);
	assign mlen = month_len(leap, mon_q);

	// Operand select for the shared unit
	always_comb begin
		unique case (state_q)
			ST_DAY:  sub_b = 32'(SECS_PER_DAY) << cnt_q;
			ST_HOUR: sub_b = 32'(SECS_PER_HOUR) << cnt_q;
			ST_MIN:  sub_b = 32'(SECS_PER_MIN) << cnt_q;
			ST_WDAY: sub_b = 32'(DAYS_PER_WEEK) << cnt_q;
			ST_YEAR: sub_b = {23'd0, ylen};
			ST_MON:  sub_b = {27'd0, mlen};
			default: sub_b = '0;
		endcase
	end

	ec_sub_unit u_sub (
		.a    (rem_q),
		.b    (sub_b),
		.ge   (ge),
		.diff (diff)
	);

	assign rem_nxt = ge ? diff : rem_q;
	assign quo_nxt = {quo_q[14:0], ge};

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (start) state_q <= ST_DAY;
				ST_DAY:  if (cnt_q == 4'd0) state_q <= ST_HOUR;
				ST_HOUR: if (cnt_q == 4'd0) state_q <= ST_MIN;
				ST_MIN:  if (cnt_q == 4'd0) state_q <= ST_WDAY;
				ST_WDAY: if (cnt_q == 4'd0) state_q <= ST_YEAR;
				ST_YEAR: if (!ge) state_q <= ST_MON;
				ST_MON:  if (!ge || mon_q == 4'(LAST_MONTH)) state_q <= ST_DONE;
				ST_DONE: if (take) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rem_q  <= epoch_seconds;
				quo_q  <= '0;
				cnt_q  <= TOP_DAY;
				year_q <= 12'(EPOCH_YEAR);
				m4_q   <= 2'(EPOCH_MOD4);
				m100_q <= 7'(EPOCH_MOD100);
				m400_q <= 9'(EPOCH_MOD400);
				mon_q  <= MON_JAN;
			end
			ST_DAY, ST_HOUR, ST_MIN, ST_WDAY: begin
				rem_q <= rem_nxt;
				quo_q <= quo_nxt;
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					quo_q <= '0;
					unique case (state_q)
						ST_DAY: begin
							days_q <= quo_nxt;
							cnt_q  <= TOP_HOUR;
						end
						ST_HOUR: begin
							hour_q <= quo_nxt[4:0];
							cnt_q  <= TOP_MIN;
						end
						ST_MIN: begin
							minute_q <= quo_nxt[5:0];
							second_q <= rem_nxt[5:0];
							rem_q    <= 32'(days_q) + 32'(EPOCH_WDAY);
							cnt_q    <= TOP_WDAY;
						end
						default: begin
							wday_q <= rem_nxt[2:0];
							rem_q  <= 32'(days_q);
						end
					endcase
				end
			end
			ST_YEAR: begin
				if (ge) begin
					rem_q  <= diff;
					year_q <= year_q + 12'd1;
					m4_q   <= m4_q + 2'd1;
					m100_q <= (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
					m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
				end else begin
					yday_q <= rem_q[8:0];
				end
			end
			ST_MON: begin
				if (ge && mon_q != 4'(LAST_MONTH)) begin
					rem_q <= diff;
					mon_q <= mon_q + 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// Status and result
	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_DONE);

	assign res.second       = second_q;
	assign res.minute       = minute_q;
	assign res.hour         = hour_q;
	assign res.year         = year_q;
	assign res.month        = mon_q;
	assign res.day_of_month = rem_q[4:0] + 5'd1;
	assign res.day_of_year  = yday_q;
	assign res.weekday      = wday_q;

endmodule

`default_nettype wire

[hw/rtl/ec_checker.sv]
// ec_checker: port-level assertions for epoch_seconds_to_calendar, and the
// bind that attaches them. Depends on the top level's ports only.
`default_nettype none

module ec_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [5:0]  second,
	input wire logic [5:0]  minute,
	input wire logic [4:0]  hour,
	input wire logic [11:0] year,
	input wire logic [3:0]  month,
	input wire logic [4:0]  day_of_month,
	input wire logic [8:0]  day_of_year,
	input wire logic [2:0]  weekday
);

	// A stalled result holds (year, day of year, second and weekday are checked)
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(year) && $stable(day_of_year)
			&& $stable(second) && $stable(weekday))
		else $error("stalled result changed");

	// Block is busy right after taking a transaction, and no result appears then
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !$rose(out_valid))
		else $error("ready or result straight after accept");

	// Time of day and calendar fields in range
	a_time_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> second < 6'd60 && minute < 6'd60 && hour < 5'd24 && weekday < 3'd7)
		else $error("time field out of range");

	a_date_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> year >= 12'd1970 && year <= 12'd2106 && month < 4'd12
			&& day_of_month != 5'd0 && day_of_year <= 9'd365)
		else $error("date field out of range");

endmodule

bind epoch_seconds_to_calendar ec_checker u_ec_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.second       (second),
	.minute       (minute),
	.hour         (hour),
	.year         (year),
	.month        (month),
	.day_of_month (day_of_month),
	.day_of_year  (day_of_year),
	.weekday      (weekday)
);

`default_nettype wire
